@@ rtl/heat_index_regression_macros.svh @@
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef HEAT_INDEX_REGRESSION_MACROS_SVH
`define HEAT_INDEX_REGRESSION_MACROS_SVH

// Same-cycle implication.
`define HIR_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/hir_pkg.sv @@
package hir_pkg;

    localparam int NSTG = 8;

    typedef logic signed [53:0] sum_t;
    typedef logic signed [41:0] corr_val_t;

    typedef enum logic [1:0] {
        CK_NONE  = 2'd0,
        CK_DRY   = 2'd1,
        CK_HUMID = 2'd2
    } corr_kind_t;

    typedef struct packed {
        sum_t a0;
        sum_t ha1;
        sum_t hha2;
    } poly_terms_t;

    typedef struct packed {
        corr_val_t  value;
        corr_kind_t kind;
    } corr_t;

    // Polynomial grouped by powers of humidity, units of 1/(1e4 * 2^24) degree.
    localparam sum_t KA0C  = -54'sd7110016370000;
    localparam sum_t KA0T  = 54'sd34376771000;
    localparam sum_t KA0TT = 54'sd11472000;
    localparam sum_t KA1C  = 54'sd170176860000;
    localparam sum_t KA1T  = 54'sd377077000;
    localparam sum_t KA1TT = 54'sd206150;
    localparam sum_t KA2C  = 54'sd91968000;
    localparam sum_t KA2T  = 54'sd143080;
    localparam sum_t KA2TT = 54'sd33;
    localparam sum_t HALF_D = 54'sd8388608000;

    // Correction windows.
    localparam logic signed [11:0] T_LO     = 12'sd800;
    localparam logic signed [11:0] T_DRY_HI = 12'sd1120;
    localparam logic signed [11:0] T_HUM_HI = 12'sd870;
    localparam logic signed [12:0] T_MID    = 13'sd950;
    localparam logic [9:0]         H_DRY    = 10'd130;
    localparam logic [9:0]         H_HUM    = 10'd850;
    localparam logic [12:0]        B_SPAN   = 13'd170;
    localparam logic [14:0]        DRY_GAIN = 15'd250;

    // Rounding and saturation, on the value scaled by 1/2^24.
    localparam logic signed [29:0] Q_LO  = -30'sd2000000;
    localparam logic signed [29:0] Q_HI  = 30'sd4001000;
    localparam logic signed [29:0] Q_OFS = 30'sd2000000;
    localparam logic [23:0]        RECIP = 24'd8589935;   // ceil(2^33 / 1000)
    localparam int                 RECIP_SHIFT = 33;
    localparam logic signed [12:0] HI_OFS = 13'sd2000;
    localparam logic signed [12:0] HI_MIN = -13'sd2000;
    localparam logic signed [12:0] HI_MAX = 13'sd4000;

    // sqrt(b/170) in Q24, floored, for b = 0..170.
    typedef logic [24:0] sqrt_tab_t [0:170];

    function automatic sqrt_tab_t sqrt_table();
        sqrt_tab_t   tab;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        for (int b = 0; b <= 170; b++) begin
            v     = (64'(b) << 48) / 64'd170;
            res   = '0;
            bit_m = 64'd1 << 62;
            for (int k = 0; k < 32; k++) begin
                if (v >= res + bit_m) begin
                    v   = v - (res + bit_m);
                    res = (res >> 1) + bit_m;
                end else begin
                    res = res >> 1;
                end
                bit_m = bit_m >> 2;
            end
            tab[b] = res[24:0];
        end
        return tab;
    endfunction

    localparam sqrt_tab_t SQRT_TAB = sqrt_table();

endpackage

@@ rtl/hir_in_if.sv @@
interface hir_in_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] temperature;
    logic [9:0]         humidity;

    modport source (output valid, output temperature, output humidity, input ready);
    modport sink   (input valid, input temperature, input humidity, output ready);
endinterface

@@ rtl/hir_out_if.sv @@
interface hir_out_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] heat_index;
    logic [1:0]         correction_kind;
    logic               saturated;

    modport source (output valid, output heat_index, output correction_kind,
                    output saturated, input ready);
    modport sink   (input valid, input heat_index, input correction_kind,
                    input saturated, output ready);
endinterface

@@ rtl/hir_poly.sv @@
module hir_poly (
    input  logic                      clk,
    input  logic [hir_pkg::NSTG-1:0]  en,
    input  logic signed [11:0]        temperature,
    input  logic [9:0]                humidity,
    output hir_pkg::poly_terms_t      terms
);
    import hir_pkg::*;

    logic signed [11:0] t0_reg;
    logic [9:0]         h0_reg;
    logic [9:0]         h1_reg;
    logic [9:0]         h2_reg;
    logic signed [23:0] tt0_reg;
    logic [19:0]        hh0_reg;
    logic [19:0]        hh1_reg;
    logic [19:0]        hh2_reg;
    sum_t               p_a0t_reg, p_a0tt_reg, p_a1t_reg, p_a1tt_reg, p_a2t_reg, p_a2tt_reg;
    sum_t               a0_reg;
    logic signed [42:0] a1_reg;
    logic signed [30:0] a2_reg;
    poly_terms_t        terms_reg;

    // stage 0: squares
    always_ff @(posedge clk) begin
        if (en[0]) begin
            t0_reg  <= temperature;
            h0_reg  <= humidity;
            tt0_reg <= temperature * temperature;
            hh0_reg <= humidity * humidity;
        end
    end

    // stage 1: coefficient products
    always_ff @(posedge clk) begin
        if (en[1]) begin
            p_a0t_reg  <= KA0T * t0_reg;
            p_a0tt_reg <= KA0TT * tt0_reg;
            p_a1t_reg  <= KA1T * t0_reg;
            p_a1tt_reg <= KA1TT * tt0_reg;
            p_a2t_reg  <= KA2T * t0_reg;
            p_a2tt_reg <= KA2TT * tt0_reg;
            h1_reg     <= h0_reg;
            hh1_reg    <= hh0_reg;
        end
    end

    // stage 2: per-power coefficients in t
    always_ff @(posedge clk) begin
        if (en[2]) begin
            a0_reg  <= KA0C + p_a0t_reg - p_a0tt_reg;
            a1_reg  <= 43'(KA1C - p_a1t_reg + p_a1tt_reg);
            a2_reg  <= 31'(p_a2t_reg - p_a2tt_reg - KA2C);
            h2_reg  <= h1_reg;
            hh2_reg <= hh1_reg;
        end
    end

    // stage 3: humidity weighting
    always_ff @(posedge clk) begin
        if (en[3]) begin
            terms_reg.a0   <= a0_reg;
            terms_reg.ha1  <= $signed({1'b0, h2_reg}) * a1_reg;
            terms_reg.hha2 <= $signed({1'b0, hh2_reg}) * a2_reg;
        end
    end

    assign terms = terms_reg;

endmodule

@@ rtl/hir_corr.sv @@
module hir_corr (
    input  logic                      clk,
    input  logic [hir_pkg::NSTG-1:0]  en,
    input  logic signed [11:0]        temperature,
    input  logic [9:0]                humidity,
    output hir_pkg::corr_t            corr
);
    import hir_pkg::*;

    logic               dry;
    logic               hum;
    logic signed [12:0] dev;
    logic [12:0]        absdev;
    logic [12:0]        b_full;
    logic [7:0]         a_dry;
    corr_kind_t         kind_next;

    corr_kind_t kind0_reg, kind1_reg;
    logic [14:0] a250_0_reg, a250_1_reg;
    logic [7:0]  bidx0_reg;
    logic [7:0]  hd0_reg;
    logic [6:0]  tw0_reg;
    logic [24:0] r1_reg;
    logic [13:0] hum1_reg;
    logic [39:0] drop;
    corr_val_t   corr2_next;
    corr_t       corr2_reg, corr3_reg;

    always_comb begin
        dry    = (humidity < H_DRY) && (temperature >= T_LO) && (temperature <= T_DRY_HI);
        hum    = !dry && (humidity > H_HUM) && (temperature >= T_LO)
                 && (temperature <= T_HUM_HI);
        dev    = 13'(temperature) - T_MID;
        absdev = dev[12] ? 13'(-dev) : 13'(dev);
        b_full = B_SPAN - absdev;
        a_dry  = 8'(H_DRY - humidity);
        if (dry) begin
            kind_next = CK_DRY;
        end else if (hum) begin
            kind_next = CK_HUMID;
        end else begin
            kind_next = CK_NONE;
        end
    end

    always_ff @(posedge clk) begin
        if (en[0]) begin
            kind0_reg  <= kind_next;
            a250_0_reg <= 15'(a_dry) * DRY_GAIN;
            bidx0_reg  <= dry ? b_full[7:0] : 8'd0;   // keep index inside the table
            hd0_reg    <= 8'(humidity - H_HUM);
            tw0_reg    <= 7'(T_HUM_HI - temperature);
        end
    end

    always_ff @(posedge clk) begin
        if (en[1]) begin
            kind1_reg  <= kind0_reg;
            a250_1_reg <= a250_0_reg;
            r1_reg     <= SQRT_TAB[bidx0_reg];
            hum1_reg   <= 14'(hd0_reg) * 14'(tw0_reg);
        end
    end

    always_comb begin
        drop = 40'(a250_1_reg) * 40'(r1_reg);
        case (kind1_reg)
            CK_DRY:   corr2_next = -$signed({2'b00, drop});
            CK_HUMID: corr2_next = $signed({3'b000, hum1_reg, 25'd0});
            default:  corr2_next = '0;
        endcase
    end

    always_ff @(posedge clk) begin
        if (en[2]) begin
            corr2_reg.value <= corr2_next;
            corr2_reg.kind  <= kind1_reg;
        end
        if (en[3]) begin
            corr3_reg <= corr2_reg;
        end
    end

    assign corr = corr3_reg;

endmodule

@@ rtl/hir_round.sv @@
module hir_round (
    input  logic                      clk,
    input  logic [hir_pkg::NSTG-1:0]  en,
    input  hir_pkg::poly_terms_t      terms,
    input  hir_pkg::corr_t            corr,
    output logic signed [12:0]        heat_index,
    output hir_pkg::corr_kind_t       kind,
    output logic                      saturated
);
    import hir_pkg::*;

    sum_t               s4_reg;
    corr_kind_t         kind4_reg, kind5_reg, kind6_reg, kind7_reg;
    logic signed [29:0] q;
    logic               lo5_reg, hi5_reg, lo6_reg, hi6_reg;
    logic [22:0]        u5_reg;
    logic [46:0]        prod6_reg;
    logic signed [12:0] hi7_reg;
    logic               sat7_reg;

    assign q = 30'(s4_reg >>> 24);

    always_ff @(posedge clk) begin
        if (en[4]) begin
            s4_reg    <= terms.a0 + terms.ha1 + terms.hha2 + sum_t'(corr.value) + HALF_D;
            kind4_reg <= corr.kind;
        end
        if (en[5]) begin
            lo5_reg   <= q < Q_LO;
            hi5_reg   <= q >= Q_HI;
            u5_reg    <= 23'(q + Q_OFS);
            kind5_reg <= kind4_reg;
        end
        // floor divide by 1000 through the reciprocal
        if (en[6]) begin
            prod6_reg <= 47'(u5_reg) * 47'(RECIP);
            lo6_reg   <= lo5_reg;
            hi6_reg   <= hi5_reg;
            kind6_reg <= kind5_reg;
        end
        if (en[7]) begin
            if (lo6_reg) begin
                hi7_reg <= HI_MIN;
            end else if (hi6_reg) begin
                hi7_reg <= HI_MAX;
            end else begin
                hi7_reg <= $signed(prod6_reg[RECIP_SHIFT +: 13]) - HI_OFS;
            end
            sat7_reg  <= lo6_reg || hi6_reg;
            kind7_reg <= kind6_reg;
        end
    end

    assign heat_index = hi7_reg;
    assign kind       = kind7_reg;
    assign saturated  = sat7_reg;

endmodule

@@ rtl/heat_index_regression.sv @@
// Rothfusz heat index, eight-stage pipeline.
// Depth: 8 register stages, stages 0 to 7, with the result offered from stage 7.
// Throughput: one transaction per cycle while result.ready is high; every stage
// holds its own valid bit and stalls only when the stage after it is full, so
// bubbles are squeezed out.
// Reset (rst_n low, asynchronous) clears all valid bits; datapath registers are not reset.
module heat_index_regression (
    input  logic      clk,
    input  logic      rst_n,
    hir_in_if.sink    sample,
    hir_out_if.source result
);
    import hir_pkg::*;

    `include "heat_index_regression_macros.svh"

    // Stage map:
    //   0  squares of t and h, correction window decode
    //   1  coefficient products, sqrt table lookup
    //   2  coefficients per power of h, correction term select
    //   3  multiply by h and h^2
    //   4  sum all terms plus half a tenth
    //   5  scale down by 2^24, saturation compare
    //   6  reciprocal multiply for the divide by 1000
    //   7  clamp, output register

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;
    poly_terms_t     terms;
    corr_t           corr;
    corr_kind_t      kind_out;

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || result.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (en[0]) begin
                v_reg[0] <= sample.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    hir_poly u_poly (
        .clk         (clk),
        .en          (en),
        .temperature (sample.temperature),
        .humidity    (sample.humidity),
        .terms       (terms)
    );

    hir_corr u_corr (
        .clk         (clk),
        .en          (en),
        .temperature (sample.temperature),
        .humidity    (sample.humidity),
        .corr        (corr)
    );

    hir_round u_round (
        .clk        (clk),
        .en         (en),
        .terms      (terms),
        .corr       (corr),
        .heat_index (result.heat_index),
        .kind       (kind_out),
        .saturated  (result.saturated)
    );

    assign sample.ready           = en[0];
    assign result.valid           = v_reg[NSTG-1];
    assign result.correction_kind = kind_out;

    // An accepted transaction always lands in the first stage.
    `HIR_ASSERT_NEXT(a_accept_lands, sample.valid && sample.ready, v_reg[0],
                     "accepted transaction lost at entry")
    // A stalled item ahead of the output register is kept.
    `HIR_ASSERT_NEXT(a_stall_keeps, v_reg[NSTG-2] && !en[NSTG-1], v_reg[NSTG-2],
                     "stalled item dropped")
    // A saturated result sits on one of the two bounds.
    `HIR_ASSERT(a_sat_bound, result.valid && result.saturated,
                (result.heat_index == HI_MAX) || (result.heat_index == HI_MIN),
                "saturated result off bound")

endmodule

@@ tb/tb.sv @@
module tb;
    import hir_pkg::*;

    // One result transaction as the checker sees it.
    typedef struct packed {
        logic signed [12:0] heat_index;
        corr_kind_t         kind;
        logic               saturated;
    } heat_result_t;

    // A directed row. Only one row carries a typed-in answer; the rest go
    // through the predictor.
    typedef struct packed {
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
        logic               typed;
        heat_result_t       answer;
    } heat_row_t;

    localparam int N_ROWS         = 20;
    localparam int RANDOM_PER_PHS = 285;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_START     = 40;   // hold-off start, in receiver cycles past N_ROWS
    localparam int HOLD_LEN       = 300;

    // Idle mixes. The long receiver hold-off happens in PH_FLAT.
    typedef enum logic [1:0] {
        PH_FLAT   = 2'd0,
        PH_SRC    = 2'd1,
        PH_SNK    = 2'd2,
        PH_BOTH   = 2'd3
    } idle_phase_t;

    logic clk;
    logic rst_n;

    hir_in_if  sample();
    hir_out_if result();

    heat_index_regression u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result)
    );

    // 10 time unit clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    heat_result_t pending_heat[$];
    int           n_fail;
    int           src_idle_pct;
    int           snk_idle_pct;
    idle_phase_t  phase;
    logic         stim_done;

    // ------------------------------------------------------------------
    // Predictor. All terms are summed exactly in units of 1/(1e4 * 2^24)
    // degree, then rounded to the nearest tenth (halves go up) and clamped.
    // ------------------------------------------------------------------
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bit_m;
        res   = 0;
        bit_m = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= res + bit_m)
            begin
                v   = v - (res + bit_m);
                res = (res >> 1) + bit_m;
            end
            else
            begin
                res = res >> 1;
            end
            bit_m = bit_m >> 2;
        end
        return res;
    endfunction

    function automatic heat_result_t predict_heat(logic signed [11:0] temp_in,
                                                  logic [9:0] hum_in);
        heat_result_t    r;
        longint          t;
        longint          h;
        longint          s;
        longint          q;
        longint          num;
        longint          dev;
        longint          span;
        longint unsigned root;
        longint          divisor;
        t       = longint'(temp_in);
        h       = longint'(hum_in);
        divisor = 64'sd1000 * (64'sd1 << 24);
        s = -64'sd711001637 * 10000
            + 64'sd34376771 * t * 1000
            + 64'sd170176860 * h * 1000
            - 64'sd3770770 * t * h * 100
            - 64'sd114720 * t * t * 100
            - 64'sd919680 * h * h * 100
            + 64'sd20615 * t * t * h * 10
            + 64'sd14308 * t * h * h * 10
            - 64'sd33 * t * t * h * h;
        r.kind = CK_NONE;
        // Dry air correction wins; the two windows never overlap anyway.
        if (h < 130 && t >= 800 && t <= 1120)
        begin
            dev  = (t > 950) ? t - 950 : 950 - t;
            span = 170 - dev;
            root = root_floor((unsigned'(span) << 48) / 64'd170);
            s    = s - (130 - h) * 250 * longint'(root);
            r.kind = CK_DRY;
        end
        else if (h > 850 && t >= 800 && t <= 870)
        begin
            s = s + (h - 850) * (870 - t) * 2 * (64'sd1 << 24);
            r.kind = CK_HUMID;
        end
        num = s + divisor / 2;
        q   = num / divisor;
        if ((num % divisor) != 0 && num < 0)
            q = q - 1;
        r.saturated = 1'b0;
        if (q < -2000)
        begin
            q = -2000;
            r.saturated = 1'b1;
        end
        else if (q > 4000)
        begin
            q = 4000;
            r.saturated = 1'b1;
        end
        r.heat_index = q[12:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Each call assigns the channel at most once per cycle and
    // returns right after the edge that accepted the transaction.
    // ------------------------------------------------------------------
    task automatic send_reading(logic signed [11:0] temp_in, logic [9:0] hum_in,
                                logic typed, heat_result_t answer);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid       <= 1'b1;
        sample.temperature <= temp_in;
        sample.humidity    <= hum_in;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        pending_heat.push_back(typed ? answer : predict_heat(temp_in, hum_in));
    endtask

    // Random reading: mostly the documented range and the correction
    // windows, some raw codes so that every input bit toggles.
    task automatic send_random();
        int sel;
        logic signed [11:0] t;
        logic [9:0] h;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            t = 12'($urandom_range(1900) - 400);
            h = 10'($urandom_range(1000));
        end
        else if (sel < 60)
        begin
            t = 12'($urandom_range(1120, 800));
            h = 10'($urandom_range(140));
        end
        else if (sel < 80)
        begin
            t = 12'($urandom_range(880, 790));
            h = 10'($urandom_range(1000, 840));
        end
        else
        begin
            t = 12'($urandom_range(4095));
            h = 10'($urandom_range(1023));
        end
        send_reading(t, h, 1'b0, '0);
    endtask

    heat_row_t rows [N_ROWS];

    initial
    begin
        // Zero input: only the constant term, -42.379 rounds to -42.4.
        rows[0]  = '{12'sd0,     10'd0,    1'b1, '{-13'sd424, CK_NONE, 1'b0}};
        rows[1]  = '{-12'sd2048, 10'd0,    1'b0, '0};
        rows[2]  = '{12'sd2047,  10'd1023, 1'b0, '0};
        rows[3]  = '{-12'sd2048, 10'd1023, 1'b0, '0};
        rows[4]  = '{12'sd2047,  10'd0,    1'b0, '0};
        rows[5]  = '{-12'sd400,  10'd1000, 1'b0, '0};
        rows[6]  = '{12'sd1500,  10'd1000, 1'b0, '0};
        rows[7]  = '{12'sd1500,  10'd0,    1'b0, '0};
        // Dry window edges and its center.
        rows[8]  = '{12'sd800,   10'd129,  1'b0, '0};
        rows[9]  = '{12'sd1120,  10'd0,    1'b0, '0};
        rows[10] = '{12'sd950,   10'd0,    1'b0, '0};
        rows[11] = '{12'sd1121,  10'd50,   1'b0, '0};
        rows[12] = '{12'sd900,   10'd130,  1'b0, '0};
        rows[13] = '{12'sd799,   10'd60,   1'b0, '0};
        // Humid window edges.
        rows[14] = '{12'sd800,   10'd1000, 1'b0, '0};
        rows[15] = '{12'sd870,   10'd851,  1'b0, '0};
        rows[16] = '{12'sd871,   10'd900,  1'b0, '0};
        rows[17] = '{12'sd820,   10'd850,  1'b0, '0};
        rows[18] = '{12'sd805,   10'd1023, 1'b0, '0};
        rows[19] = '{12'sd1000,  10'd500,  1'b0, '0};
    end

    // Main sequence.
    initial
    begin
        n_fail             = 0;
        stim_done          = 1'b0;
        src_idle_pct       = 0;
        snk_idle_pct       = 0;
        phase              = PH_FLAT;
        rst_n              = 1'b0;
        sample.valid       = 1'b0;
        sample.temperature = '0;
        sample.humidity    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_reading(rows[i].temperature, rows[i].humidity, rows[i].typed,
                         rows[i].answer);

        for (int p = 0; p < 4; p++)
        begin
            phase = idle_phase_t'(p);
            case (phase)
                PH_FLAT: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                PH_SRC:  begin src_idle_pct = 79; snk_idle_pct = 0;  end
                PH_SNK:  begin src_idle_pct = 0;  snk_idle_pct = 79; end
                default: begin src_idle_pct = 26; snk_idle_pct = 26; end
            endcase
            repeat (RANDOM_PER_PHS)
                send_random();
        end
        sample.valid <= 1'b0;
        stim_done = 1'b1;

        while (pending_heat.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("PASS heat_index_regression");
        else
            $display("FAIL heat_index_regression");
        $finish;
    end

    // Receiver. Its own cycle count places one long hold-off early in the
    // flat phase, while the sender keeps offering, so the pipe backs up.
    int rx_cycle;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            rx_cycle     <= 0;
        end
        else
        begin
            rx_cycle <= (phase == PH_FLAT) ? rx_cycle + 1 : 0;
            if (phase == PH_FLAT && !stim_done && rx_cycle >= HOLD_START + N_ROWS
                && rx_cycle < HOLD_START + N_ROWS + HOLD_LEN)
                result.ready <= 1'b0;
            else
                result.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    heat_result_t want;
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_heat.size() == 0)
            begin
                $error("unexpected result transaction heat_index=%0d",
                       result.heat_index);
                n_fail++;
            end
            else
            begin
                want = pending_heat.pop_front();
                if (result.heat_index !== want.heat_index)
                begin
                    $error("heat_index expected %0d got %0d", want.heat_index,
                           result.heat_index);
                    n_fail++;
                end
                if (result.correction_kind !== want.kind)
                begin
                    $error("correction_kind expected %0d got %0d", want.kind,
                           result.correction_kind);
                    n_fail++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated expected %0d got %0d", want.saturated,
                           result.saturated);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (sample.valid && sample.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL heat_index_regression");
            $finish;
        end
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hir_pkg.sv
rtl/hir_in_if.sv
rtl/hir_out_if.sv
rtl/hir_poly.sv
rtl/hir_corr.sv
rtl/hir_round.sv
rtl/heat_index_regression.sv
tb/tb.sv
